// File: hdl/btod_pkg.sv
// shared types and constants for the bcd time-of-day clock
`default_nettype none
package btod_pkg;

	// one bcd time, packed so that seconds units sits in the lowest bits
	typedef struct packed {
		logic [1:0] hour_tens;
		logic [3:0] hour_units;
		logic [2:0] min_tens;
		logic [3:0] min_units;
		logic [2:0] sec_tens;
		logic [3:0] sec_units;
	} btod_time_t;

	// raw digits of a set word, seconds units in the lowest bits
	typedef struct packed {
		logic [3:0] hour_tens;
		logic [3:0] hour_units;
		logic [3:0] min_tens;
		logic [3:0] min_units;
		logic [3:0] sec_tens;
		logic [3:0] sec_units;
	} btod_raw_t;

	localparam int unsigned PRESCALE_W = 16;
	localparam logic [PRESCALE_W-1:0] PRESCALE_RESET = 16'd346;

	localparam logic ACTION_TICK = 1'b0;
	localparam logic ACTION_SET  = 1'b1;

	localparam logic [3:0] UNITS_MAX     = 4'd9;
	localparam logic [3:0] TENS_MAX      = 4'd5;
	localparam logic [3:0] HOUR_TENS_MAX = 4'd2;
	localparam logic [3:0] HOUR_LAST_U   = 4'd3;

endpackage
`default_nettype wire

// File: hdl/bcd_time_of_day_clock_top.sv
// top level of the 24-hour bcd time-of-day clock
// every input word gives exactly one output word, registered in the cycle after it is taken;
// a word is taken every cycle as long as the output register is empty or being
// drained, so the block sustains one word per cycle. tuser selects the action:
// 0 is one timer overflow tick, 1 loads the time from the six digits in tdata.
// ticks run a prescaler whose limit alternates between prescale_base and
// prescale_base+1; at the limit one second is added with a bcd carry and
// 23:59:59 wraps to 00:00:00. a set with any digit out of range or an hour
// above 23 clears the time, and a set leaves the prescaler untouched. the
// output word carries the time after the input word and, in tuser, a flag
// for a second just completed. prescale_base resets to 346 and should only be
// written while no word is in flight.
`default_nettype none
module bcd_time_of_day_clock_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration: prescale_base
	input  wire logic        cfg_wen,
	input  wire logic [15:0] cfg_wdata,
	// input words
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// set_sec_units, set_sec_tens, set_min_units, set_min_tens, set_hour_units,
	// set_hour_tens, 4 bits each
	input  wire logic [23:0] s_tdata,
	// action
	input  wire logic        s_tuser,
	// output words
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// sec_units[3:0], sec_tens[6:4], min_units[10:7], min_tens[13:11],
	// hour_units[17:14], hour_tens[19:18], zero pad[23:20]
	output logic [23:0]      m_tdata,
	// second_elapsed
	output logic             m_tuser
);

	logic [btod_pkg::PRESCALE_W-1:0] prescale_base_q;
	btod_pkg::btod_time_t            time_q;
	btod_pkg::btod_time_t            time_inc;
	btod_pkg::btod_time_t            time_set;
	btod_pkg::btod_time_t            res_time_q;
	logic                            res_elapsed_q;
	logic                            out_valid_q;
	logic                            in_accept;
	logic                            tick_en;
	logic                            sec_done;

	// the output register frees itself in the same cycle it is drained
	assign s_tready  = !out_valid_q || m_tready;
	assign in_accept = s_tvalid && s_tready;
	assign tick_en   = in_accept && (s_tuser == btod_pkg::ACTION_TICK);

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prescale_base_q <= btod_pkg::PRESCALE_RESET;
		end else if (cfg_wen) begin
			prescale_base_q <= cfg_wdata;
		end
	end

	// tick counter and long/short second phase
	btod_prescale u_prescale (
		.clk      (clk),
		.arst_n   (arst_n),
		.tick_en  (tick_en),
		.base     (prescale_base_q),
		.sec_done (sec_done)
	);

	// next time on a completed second
	btod_incr u_incr (
		.cur (time_q),
		.nxt (time_inc)
	);

	// checked time from a set word
	btod_set u_set (
		.raw    (btod_pkg::btod_raw_t'(s_tdata)),
		.loaded (time_set)
	);

	// time-of-day state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_q <= '0;
		end else if (in_accept) begin
			if (s_tuser == btod_pkg::ACTION_SET) begin
				time_q <= time_set;
			end else if (sec_done) begin
				time_q <= time_inc;
			end
		end
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_accept) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output payload, loaded with the time after this word
	always_ff @(posedge clk) begin
		if (in_accept) begin
			if (s_tuser == btod_pkg::ACTION_SET) begin
				res_time_q    <= time_set;
				res_elapsed_q <= 1'b0;
			end else begin
				res_time_q    <= sec_done ? time_inc : time_q;
				res_elapsed_q <= sec_done;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'd0, res_time_q};
	assign m_tuser  = res_elapsed_q;

endmodule
`default_nettype wire

// File: hdl/btod_prescale.sv
// tick prescaler with alternating base and base+1 limit
`default_nettype none
module btod_prescale (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              tick_en,
	input  wire logic [btod_pkg::PRESCALE_W-1:0]   base,
	output logic                                   sec_done
);

	logic [btod_pkg::PRESCALE_W-1:0] tick_count_q;
	logic                            phase_q;
	logic [btod_pkg::PRESCALE_W:0]   next_count;
	logic [btod_pkg::PRESCALE_W:0]   limit;

	// compare at one extra bit so base+1 may reach 65536
	assign next_count = {1'b0, tick_count_q} + {{btod_pkg::PRESCALE_W{1'b0}}, 1'b1};
	assign limit      = {1'b0, base} + {{btod_pkg::PRESCALE_W{1'b0}}, phase_q};
	assign sec_done   = tick_en && (next_count >= limit);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_count_q <= '0;
			phase_q      <= 1'b0;
		end else if (tick_en) begin
			if (sec_done) begin
				tick_count_q <= '0;
				phase_q      <= ~phase_q;
			end else begin
				tick_count_q <= next_count[btod_pkg::PRESCALE_W-1:0];
			end
		end
	end

endmodule
`default_nettype wire

// File: hdl/btod_incr.sv
// one-second bcd increment with 23:59:59 wrap
`default_nettype none
module btod_incr (
	input  wire btod_pkg::btod_time_t cur,
	output btod_pkg::btod_time_t      nxt
);

	logic c_su, c_st, c_mu, c_mt;

	always_comb begin
		nxt  = cur;
		c_su = (cur.sec_units == btod_pkg::UNITS_MAX);
		c_st = c_su && (cur.sec_tens == btod_pkg::TENS_MAX[2:0]);
		c_mu = c_st && (cur.min_units == btod_pkg::UNITS_MAX);
		c_mt = c_mu && (cur.min_tens == btod_pkg::TENS_MAX[2:0]);

		nxt.sec_units = c_su ? 4'd0 : cur.sec_units + 4'd1;
		if (c_su) begin
			nxt.sec_tens = c_st ? 3'd0 : cur.sec_tens + 3'd1;
		end
		if (c_st) begin
			nxt.min_units = c_mu ? 4'd0 : cur.min_units + 4'd1;
		end
		if (c_mu) begin
			nxt.min_tens = c_mt ? 3'd0 : cur.min_tens + 3'd1;
		end
		if (c_mt) begin
			if (cur.hour_tens == btod_pkg::HOUR_TENS_MAX[1:0] &&
			    cur.hour_units == btod_pkg::HOUR_LAST_U) begin
				nxt = '0;
			end else if (cur.hour_units == btod_pkg::UNITS_MAX) begin
				nxt.hour_units = 4'd0;
				nxt.hour_tens  = cur.hour_tens + 2'd1;
			end else begin
				nxt.hour_units = cur.hour_units + 4'd1;
			end
		end
	end

endmodule
`default_nettype wire

// File: hdl/btod_set.sv
// range check of a set word, invalid time loads zero
`default_nettype none
module btod_set (
	input  wire btod_pkg::btod_raw_t raw,
	output btod_pkg::btod_time_t     loaded
);

	logic bad;

	always_comb begin
		bad = (raw.sec_units  > btod_pkg::UNITS_MAX) ||
		      (raw.sec_tens   > btod_pkg::TENS_MAX) ||
		      (raw.min_units  > btod_pkg::UNITS_MAX) ||
		      (raw.min_tens   > btod_pkg::TENS_MAX) ||
		      (raw.hour_units > btod_pkg::UNITS_MAX) ||
		      (raw.hour_tens  > btod_pkg::HOUR_TENS_MAX) ||
		      (raw.hour_tens == btod_pkg::HOUR_TENS_MAX &&
		       raw.hour_units > btod_pkg::HOUR_LAST_U);
		if (bad) begin
			loaded = '0;
		end else begin
			loaded.sec_units  = raw.sec_units;
			loaded.sec_tens   = raw.sec_tens[2:0];
			loaded.min_units  = raw.min_units;
			loaded.min_tens   = raw.min_tens[2:0];
			loaded.hour_units = raw.hour_units;
			loaded.hour_tens  = raw.hour_tens[1:0];
		end
	end

endmodule
`default_nettype wire
